FILE: src/tdmf_pkg.sv
package tdmf_pkg;

    localparam int ANCHOR_COUNT_DEF  = 4;
    localparam int HISTORY_DEPTH_DEF = 30;

    localparam int ANCHOR_W   = 2;
    localparam int TIME_W     = 32;
    localparam int SCALE_W    = 16;
    localparam int DIST_W     = 20;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX   = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd30748;
    localparam logic [DIST_W-1:0]  MIN_RST   = 20'd0;
    localparam logic [DIST_W-1:0]  MAX_RST   = 20'd16000;

    localparam logic [CNT_OUT_W-1:0] COUNT_MAX = 5'd31;

    typedef logic [DIST_W-1:0] t_dist;

    // control word from the sequencer to the rank counter
    typedef struct packed {
        logic clr;
        logic load_key;
        logic sample_en;
    } t_rank_ctl;

endpackage

FILE: src/tdmf_ram.sv
module tdmf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 120,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tdmf_range.sv
module tdmf_range (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tdmf_pkg::TIME_W-1:0]   i_round_a,
    input  logic [tdmf_pkg::TIME_W-1:0]   i_reply_a,
    input  logic [tdmf_pkg::TIME_W-1:0]   i_round_b,
    input  logic [tdmf_pkg::TIME_W-1:0]   i_reply_b,
    input  logic [tdmf_pkg::SCALE_W-1:0]  i_scale,
    output logic                          o_done,
    output tdmf_pkg::t_dist               o_dist
);
    import tdmf_pkg::*;

    localparam int DIFF_W = TIME_W + 1;
    localparam int SUM_W  = TIME_W + 3;
    localparam int T_W    = TIME_W - 1;
    localparam int PROD_W = T_W + SCALE_W;

    logic [3:0]        r_v;
    logic [DIFF_W-1:0] r_s1, r_s2, r_s3;
    logic [SUM_W-1:0]  r_sum;
    logic              r_pos;
    logic [PROD_W-1:0] r_prod;
    t_dist             r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 0: the three interval differences
        r_s1 <= {i_round_a[TIME_W-1], i_round_a} - {i_reply_b[TIME_W-1], i_reply_b};
        r_s2 <= {i_round_b[TIME_W-1], i_round_b} - {i_reply_a[TIME_W-1], i_reply_a};
        r_s3 <= {i_reply_a[TIME_W-1], i_reply_a} - {i_reply_b[TIME_W-1], i_reply_b};
        // stage 1: combined ranging time, four times over
        r_sum <= {{2{r_s1[DIFF_W-1]}}, r_s1} + {{2{r_s2[DIFF_W-1]}}, r_s2}
               - {{2{r_s3[DIFF_W-1]}}, r_s3};
        // stage 2: time > 0 exactly when sum >= 4; positive sum stays below 2^33
        r_pos  <= !r_sum[SUM_W-1] && (r_sum[SUM_W-1:2] != '0);
        r_prod <= PROD_W'(r_sum[TIME_W:2]) * PROD_W'(i_scale);
        // stage 3: drop 12 fraction bits and saturate
        if (!r_pos) begin
            r_dist <= '0;
        end else if (r_prod[PROD_W-1:DIST_W+12] != '0) begin
            r_dist <= '1;
        end else begin
            r_dist <= r_prod[DIST_W+11:12];
        end
    end

    assign o_done = r_v[3];
    assign o_dist = r_dist;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_v))
        else $error("range pipeline holds more than one word");

endmodule

FILE: src/tdmf_rank.sv
module tdmf_rank #(
    parameter int CNT_W = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tdmf_pkg::t_rank_ctl i_ctl,
    input  tdmf_pkg::t_dist     i_key,
    input  tdmf_pkg::t_dist     i_data,
    input  tdmf_pkg::t_dist     i_min,
    input  tdmf_pkg::t_dist     i_max,
    output logic                o_in_win,
    output tdmf_pkg::t_dist     o_key,
    output logic [CNT_W-1:0]    o_lt,
    output logic [CNT_W-1:0]    o_le
);
    import tdmf_pkg::*;

    t_dist            r_key;
    logic [CNT_W-1:0] r_lt, r_le;

    assign o_in_win = (i_data >= i_min) && (i_data <= i_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= '0;
            r_le <= '0;
        end else if (i_ctl.clr) begin
            r_lt <= '0;
            r_le <= '0;
        end else if (i_ctl.sample_en && o_in_win) begin
            if (i_data < r_key) begin
                r_lt <= r_lt + CNT_W'(1);
            end
            if (i_data <= r_key) begin
                r_le <= r_le + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_key) begin
            r_key <= i_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_le  = r_le;

    a_le_covers_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_le >= r_lt)
        else $error("rank counts out of order");

endmodule

FILE: src/twr_distance_median_filter.sv
// Two-way ranging distance with a per-anchor sliding median.
// Input channel (i_valid/o_ready): one word per ranging exchange, anchor
// index plus four signed intervals. Output channel (o_valid/i_ready): anchor,
// raw distance, median of the anchor's in-window history and the count.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx at once
// (0 scale, 1 window low, 2 window high); change it only while idle.
// Sequence: the distance pipe, a history write, then a counting sweep over
// the anchor's history, then per history entry a fetch plus another sweep
// when it lies in the window. The run time per word is set by the single
// read port of the history RAM feeding one compare unit.
// o_ready is high only while the sequencer is idle. The result sits in an
// output register; a stalled receiver does not block acceptance of the next
// input word, but that word finishes only once the earlier result is taken.
// Reset (synchronous, active low) restores the register defaults and
// empties every history through per-anchor fill counts; no clearing pass.
module twr_distance_median_filter #(
    parameter int ANCHOR_COUNT  = tdmf_pkg::ANCHOR_COUNT_DEF,
    parameter int HISTORY_DEPTH = tdmf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tdmf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tdmf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [tdmf_pkg::ANCHOR_W-1:0]     i_anchor_index,
    input  logic signed [tdmf_pkg::TIME_W-1:0] i_round_a,
    input  logic signed [tdmf_pkg::TIME_W-1:0] i_reply_a,
    input  logic signed [tdmf_pkg::TIME_W-1:0] i_round_b,
    input  logic signed [tdmf_pkg::TIME_W-1:0] i_reply_b,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tdmf_pkg::ANCHOR_W-1:0]     o_anchor_out,
    output logic [tdmf_pkg::DIST_W-1:0]       o_raw_distance,
    output logic [tdmf_pkg::DIST_W-1:0]       o_median_dist,
    output logic [tdmf_pkg::CNT_OUT_W-1:0]    o_win_count
);
    import tdmf_pkg::*;

    localparam int MEM_DEPTH = ANCHOR_COUNT * HISTORY_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int IDX_W     = $clog2(HISTORY_DEPTH);
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int AIDX_W    = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
    localparam int AEXT_W    = (AIDX_W > ANCHOR_W) ? AIDX_W : ANCHOR_W;
    localparam int CEXT_W    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_WRITE, S_SWEEP, S_DRAIN, S_EVAL, S_KEY_RD, S_KEY_LD, S_FIN
    } t_state;

    t_state              r_state;
    logic [SCALE_W-1:0]  r_scale;
    t_dist               r_min, r_max;
    logic [ANCHOR_W-1:0] r_anchor;
    logic [AIDX_W-1:0]   r_aidx;
    logic                r_in_range;
    logic [ADDR_W-1:0]   r_base;
    t_dist               r_raw;
    logic [IDX_W-1:0]    r_wp   [ANCHOR_COUNT];
    logic [CNT_W-1:0]    r_fill [ANCHOR_COUNT];
    logic [IDX_W-1:0]    r_i, r_j, r_pend_idx;
    logic                r_pend;
    logic                r_counting;
    logic [CNT_W-1:0]    r_n;
    t_dist               r_lo, r_hi;
    logic                r_out_valid;
    logic [ANCHOR_W-1:0] r_out_anchor;
    t_dist               r_out_raw, r_out_filt;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic              accept;
    logic [AEXT_W-1:0] anchor_ext;
    logic              rng_done;
    t_dist             rng_dist;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    t_dist             ram_q, q_m;
    logic [IDX_W-1:0]  mask_idx;
    t_rank_ctl         rank_ctl;
    t_dist             rank_key_in, rank_key;
    logic              in_win;
    logic [CNT_W-1:0]  lt, le;
    logic [CNT_W-1:0]  k_lo, k_hi;
    logic [DIST_W:0]   mid_sum;
    logic [CEXT_W-1:0] n_ext;

    assign o_ready    = (r_state == S_IDLE);
    assign accept     = i_valid && o_ready;
    assign anchor_ext = AEXT_W'(i_anchor_index);

    tdmf_range u_range (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_round_a (i_round_a),
        .i_reply_a (i_reply_a),
        .i_round_b (i_round_b),
        .i_reply_b (i_reply_b),
        .i_scale   (r_scale),
        .o_done    (rng_done),
        .o_dist    (rng_dist)
    );

    assign ram_we    = (r_state == S_WRITE);
    assign ram_waddr = r_base + ADDR_W'(r_wp[r_aidx]);
    assign ram_raddr = r_base + ADDR_W'((r_state == S_KEY_RD) ? r_i : r_j);

    tdmf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MEM_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_raw),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // entries past the fill count were never written since reset: read as zero
    assign mask_idx = (r_state == S_KEY_LD) ? r_i : r_pend_idx;
    assign q_m      = (CNT_W'(mask_idx) < r_fill[r_aidx]) ? ram_q : '0;

    always_comb begin
        rank_ctl    = '0;
        rank_key_in = q_m;
        case (r_state)
            S_WRITE: begin
                // all-ones key: le counts every in-window entry
                rank_ctl.clr      = 1'b1;
                rank_ctl.load_key = 1'b1;
                rank_key_in       = '1;
            end
            S_KEY_LD: begin
                rank_ctl.clr      = in_win;
                rank_ctl.load_key = in_win;
            end
            default: begin
            end
        endcase
        rank_ctl.sample_en = r_pend;
    end

    tdmf_rank #(
        .CNT_W (CNT_W)
    ) u_rank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rank_ctl),
        .i_key    (rank_key_in),
        .i_data   (q_m),
        .i_min    (r_min),
        .i_max    (r_max),
        .o_in_win (in_win),
        .o_key    (rank_key),
        .o_lt     (lt),
        .o_le     (le)
    );

    assign k_lo    = (r_n - CNT_W'(1)) >> 1;
    assign k_hi    = r_n >> 1;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign n_ext   = CEXT_W'(r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
            r_min   <= MIN_RST;
            r_max   <= MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                REG_MIN:   r_min   <= i_cfg_data[DIST_W-1:0];
                REG_MAX:   r_max   <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < ANCHOR_COUNT; a++) begin
                r_wp[a]   <= '0;
                r_fill[a] <= '0;
            end
        end else begin
            // S_FIN reloads the output register on its own
            if (r_out_valid && i_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            r_pend     <= (r_state == S_SWEEP);
            r_pend_idx <= r_j;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_anchor   <= i_anchor_index;
                        r_aidx     <= anchor_ext[AIDX_W-1:0];
                        r_in_range <= (32'(i_anchor_index) < ANCHOR_COUNT);
                        r_n        <= '0;
                        r_lo       <= '0;
                        r_hi       <= '0;
                        r_state    <= S_DIST;
                    end
                end
                S_DIST: begin
                    r_base <= ADDR_W'(32'(r_aidx) * HISTORY_DEPTH);
                    if (rng_done) begin
                        r_raw   <= rng_dist;
                        r_state <= r_in_range ? S_WRITE : S_FIN;
                    end
                end
                S_WRITE: begin
                    r_wp[r_aidx] <= (r_wp[r_aidx] == LAST_IDX) ? '0
                                                              : r_wp[r_aidx] + IDX_W'(1);
                    if (r_fill[r_aidx] != DEPTH_CNT) begin
                        r_fill[r_aidx] <= r_fill[r_aidx] + CNT_W'(1);
                    end
                    r_j        <= '0;
                    r_counting <= 1'b1;
                    r_state    <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (r_j == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_counting) begin
                        r_n        <= le;
                        r_counting <= 1'b0;
                        r_i        <= '0;
                        r_state    <= (le == '0) ? S_FIN : S_KEY_RD;
                    end else begin
                        // key holds rank positions lt .. le-1 of the sorted window
                        if (lt <= k_lo && k_lo < le) begin
                            r_lo <= rank_key;
                        end
                        if (lt <= k_hi && k_hi < le) begin
                            r_hi <= rank_key;
                        end
                        if (r_i == LAST_IDX) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_KEY_RD;
                        end
                    end
                end
                S_KEY_RD: begin
                    r_state <= S_KEY_LD;
                end
                S_KEY_LD: begin
                    if (in_win) begin
                        r_j     <= '0;
                        r_state <= S_SWEEP;
                    end else if (r_i == LAST_IDX) begin
                        r_state <= S_FIN;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_KEY_RD;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_anchor <= r_anchor;
                        r_out_raw    <= r_raw;
                        r_out_filt   <= mid_sum[DIST_W:1];
                        r_out_cnt    <= (n_ext > CEXT_W'(COUNT_MAX)) ? COUNT_MAX
                                                                     : n_ext[CNT_OUT_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_anchor_out   = r_out_anchor;
    assign o_raw_distance = r_out_raw;
    assign o_median_dist  = r_out_filt;
    assign o_win_count    = r_out_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> CEXT_W'(o_win_count) <= CEXT_W'(HISTORY_DEPTH))
        else $error("window count exceeds history depth");

    a_empty_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_win_count == '0) |-> o_median_dist == '0)
        else $error("median reported with empty window");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_in_range) |-> r_wp[r_aidx] <= LAST_IDX)
        else $error("write pointer past ring end");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_in_range) |-> r_fill[r_aidx] <= DEPTH_CNT)
        else $error("fill count past ring depth");

endmodule
